>>> rtl/fqp_pkg.sv
// shared types and constants for the fastq record parser
package fqp_pkg;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_AT    = 8'h40;
  localparam logic [7:0] PRINT_LO = 8'h21;
  localparam logic [7:0] PRINT_HI = 8'h7E;

  typedef enum logic [2:0] {
    PH_GAP   = 3'd0,
    PH_NAME  = 3'd1,
    PH_BASES = 3'd2,
    PH_PLUS  = 3'd3,
    PH_QUAL  = 3'd4,
    PH_HALT  = 3'd5
  } fqp_phase_e;

  typedef enum logic [2:0] {
    KIND_NAME       = 3'd0,
    KIND_BASE       = 3'd1,
    KIND_QUAL       = 3'd2,
    KIND_DONE       = 3'd3,
    KIND_CLEAN_END  = 3'd4,
    KIND_BAD_MARKER = 3'd5,
    KIND_INCOMPLETE = 3'd6
  } fqp_kind_e;

  typedef enum logic [1:0] {
    CFG_ORIENT    = 2'd0,
    CFG_MAX_READS = 2'd1,
    CFG_MAX_BASES = 2'd2
  } fqp_cfg_idx_e;

  typedef struct packed {
    logic [3:0]  orient_flags;
    logic [31:0] read_limit;
    logic [31:0] max_bases;
  } fqp_cfg_t;

  typedef struct packed {
    fqp_kind_e   kind;
    logic [7:0]  value;
    logic [15:0] record_len;
    logic [31:0] line_number;
    logic [31:0] chunk_reads;
    logic        chunk_full;
  } fqp_result_t;

  typedef struct packed {
    logic res_valid;
    logic halted;
  } fqp_status_t;

endpackage

>>> rtl/fqp_if.sv
// valid/ready channel interfaces for the parser input and result streams
interface fqp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       at_end;

  modport source (output valid, output in_byte, output at_end, input ready);
  modport sink (input valid, input in_byte, input at_end, output ready);
endinterface

interface fqp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [7:0]  value;
  logic [15:0] record_len;
  logic [31:0] line_number;
  logic [31:0] chunk_reads;
  logic        chunk_full;

  modport source (output valid, output kind, output value, output record_len,
                  output line_number, output chunk_reads, output chunk_full,
                  input ready);
  modport sink (input valid, input kind, input value, input record_len,
                input line_number, input chunk_reads, input chunk_full,
                output ready);
endinterface

>>> rtl/fqp_cfg_regs.sv
// configuration register file
module fqp_cfg_regs (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [31:0]       cfg_data_i,
  output fqp_pkg::fqp_cfg_t cfg_o
);
  import fqp_pkg::*;

  fqp_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ORIENT:    cfg_d.orient_flags = cfg_data_i[3:0];
        CFG_MAX_READS: cfg_d.read_limit = cfg_data_i;
        CFG_MAX_BASES: cfg_d.max_bases = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.orient_flags <= 4'd1;
      cfg_q.read_limit   <= '1;
      cfg_q.max_bases    <= '1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;
endmodule

>>> rtl/fqp_core.sv
// parse state machine, line and chunk counters, result formation
module fqp_core #(
  parameter int unsigned LONG_READ_RESERVE = 32768
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  fqp_pkg::fqp_cfg_t    cfg_i,
  input  logic [7:0]           in_byte_i,
  input  logic                 at_end_i,
  input  logic                 fire_i,
  output fqp_pkg::fqp_status_t status_o,
  output fqp_pkg::fqp_result_t result_o
);
  import fqp_pkg::*;

  localparam int RES_W = $clog2(LONG_READ_RESERVE + 1) + 3;

  fqp_phase_e  phase_q, phase_d;
  logic [31:0] line_q, line_d;
  logic [15:0] qual_q, qual_d;
  logic [31:0] reads_q, reads_d;
  logic [39:0] bases_q, bases_d;

  logic        eol, printable, count_line;
  logic [2:0]  mult;
  logic [18:0] qprod;
  logic [40:0] b_sum;
  logic [39:0] b_sat;
  logic [32:0] r_sum;
  logic [31:0] r_sat;
  logic [32:0] r_lim;
  logic [RES_W-1:0] res_prod;
  logic [40:0] b_lim;
  logic        full;
  fqp_result_t res;
  logic        res_valid;

  assign eol       = (in_byte_i == CH_NL) || (in_byte_i == CH_NUL);
  assign printable = (in_byte_i >= PRINT_LO) && (in_byte_i <= PRINT_HI);

  always_comb begin
    count_line = 1'b0;
    if (!at_end_i) begin
      case (phase_q) inside
        PH_GAP, PH_BASES: count_line = (in_byte_i == CH_NL);
        PH_NAME, PH_PLUS, PH_QUAL: count_line = eol;
        default: count_line = 1'b0;
      endcase
    end
  end

  assign line_d = (count_line && (line_q != '1)) ? line_q + 32'd1 : line_q;

  // record accounting at the end of a quality line
  assign mult  = 3'({2'b0, cfg_i.orient_flags[0]} + {2'b0, cfg_i.orient_flags[1]}
                  + {2'b0, cfg_i.orient_flags[2]} + {2'b0, cfg_i.orient_flags[3]});
  assign qprod = 19'(mult) * 19'(qual_q);
  assign b_sum = {1'b0, bases_q} + 41'(qprod);
  assign b_sat = b_sum[40] ? '1 : b_sum[39:0];
  assign r_sum = {1'b0, reads_q} + 33'(mult);
  assign r_sat = r_sum[32] ? '1 : r_sum[31:0];

  // fit thresholds depend on configuration only
  assign res_prod = RES_W'(mult) * RES_W'(LONG_READ_RESERVE);
  assign r_lim    = {1'b0, cfg_i.read_limit} - 33'(mult);
  assign b_lim    = 41'(cfg_i.max_bases) - 41'(res_prod);
  assign full     = r_lim[32] || (r_sat > r_lim[31:0])
                 || b_lim[40] || (b_sat > b_lim[39:0]);

  // next state
  always_comb begin
    phase_d = phase_q;
    qual_d  = qual_q;
    reads_d = reads_q;
    bases_d = bases_q;
    unique case (phase_q)
      PH_GAP: begin
        if (at_end_i) begin
          phase_d = PH_HALT;
        end else if (in_byte_i == CH_AT) begin
          phase_d = PH_NAME;
          qual_d  = '0;
        end else if ((in_byte_i != CH_NL) && (in_byte_i != CH_SP)) begin
          phase_d = PH_HALT;
        end
      end
      PH_NAME: begin
        if (at_end_i) phase_d = PH_HALT;
        else if (eol) phase_d = PH_BASES;
      end
      PH_BASES: begin
        if (at_end_i) phase_d = PH_HALT;
        else if ((in_byte_i == CH_PLUS) || (in_byte_i == CH_NUL)) phase_d = PH_PLUS;
      end
      PH_PLUS: begin
        if (at_end_i) begin
          phase_d = PH_HALT;
        end else if (eol) begin
          phase_d = PH_QUAL;
          qual_d  = '0;
        end
      end
      PH_QUAL: begin
        if (at_end_i) begin
          phase_d = PH_HALT;
        end else if (eol) begin
          phase_d = PH_GAP;
          qual_d  = '0;
          reads_d = full ? '0 : r_sat;
          bases_d = full ? '0 : b_sat;
        end else if (qual_q != '1) begin
          qual_d = qual_q + 16'd1;
        end
      end
      PH_HALT: phase_d = PH_HALT;
      default: phase_d = PH_HALT;
    endcase
  end

  // result
  always_comb begin
    res_valid       = 1'b0;
    res.kind        = KIND_NAME;
    res.value       = '0;
    res.record_len  = '0;
    res.line_number = line_d;
    res.chunk_reads = reads_q;
    res.chunk_full  = 1'b0;
    unique case (phase_q)
      PH_GAP: begin
        if (at_end_i) begin
          res_valid = 1'b1;
          res.kind  = KIND_CLEAN_END;
        end else if ((in_byte_i != CH_NL) && (in_byte_i != CH_SP)
                     && (in_byte_i != CH_AT)) begin
          res_valid = 1'b1;
          res.kind  = KIND_BAD_MARKER;
          res.value = in_byte_i;
        end
      end
      PH_NAME: begin
        if (at_end_i) begin
          res_valid = 1'b1;
          res.kind  = KIND_INCOMPLETE;
        end else if (!eol) begin
          res_valid = 1'b1;
          res.kind  = KIND_NAME;
          res.value = in_byte_i;
        end
      end
      PH_BASES: begin
        if (at_end_i) begin
          res_valid = 1'b1;
          res.kind  = KIND_INCOMPLETE;
        end else if ((in_byte_i != CH_PLUS) && printable) begin
          res_valid = 1'b1;
          res.kind  = KIND_BASE;
          res.value = in_byte_i;
        end
      end
      PH_PLUS: begin
        if (at_end_i) begin
          res_valid = 1'b1;
          res.kind  = KIND_INCOMPLETE;
        end
      end
      PH_QUAL: begin
        res_valid = 1'b1;
        if (at_end_i) begin
          res.kind = KIND_INCOMPLETE;
        end else if (eol) begin
          res.kind        = KIND_DONE;
          res.record_len  = qual_q;
          res.chunk_reads = r_sat;
          res.chunk_full  = full;
        end else begin
          res.kind  = KIND_QUAL;
          res.value = in_byte_i;
        end
      end
      PH_HALT: res_valid = 1'b0;
      default: res_valid = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_GAP;
      line_q  <= '0;
      qual_q  <= '0;
      reads_q <= '0;
      bases_q <= '0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      line_q  <= line_d;
      qual_q  <= qual_d;
      reads_q <= reads_d;
      bases_q <= bases_d;
    end
  end

  assign status_o.res_valid = res_valid;
  assign status_o.halted    = (phase_q == PH_HALT);
  assign result_o           = res;
endmodule

>>> rtl/fqp_out_stage.sv
// result register between the parser and the output channel
module fqp_out_stage (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  fqp_pkg::fqp_result_t result_i,
  input  logic                 ready_i,
  output logic                 valid_o,
  output fqp_pkg::fqp_result_t result_o
);
  import fqp_pkg::*;

  logic        valid_q;
  fqp_result_t data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= result_i;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = data_q;
endmodule

>>> rtl/fastq_record_parser.sv
// fastq record parser top level
// Input channel in_i carries one text byte per item (in_byte) or an end mark
// (at_end). Output channel out_o carries zero or one result per input item:
// name, base and quality bytes, record done with length and chunk figures,
// clean end, bad marker or incomplete record. Configuration registers are
// written through cfg_we_i / cfg_idx_i / cfg_data_i; the user must do so only
// while no item is in flight, which the block does not enforce. An accepted
// byte sits in an input register; when it fires, the parser updates its state
// and loads the result register, which drives out_o. One item is taken every
// cycle unless a result must wait; the parse step and the chunk fit test fit
// in the single stage between the two registers. Items that give no result
// leave even while out_o stalls; an item that gives a result waits in the
// input register until the result register is free, and ready on in_i then drops.
// Reset clears the parse state to the gap before a record, zeroes the line,
// length and chunk counters and loads the register reset values. After a
// clean end, bad marker or incomplete result the parser halts and drops
// every later item until reset.
module fastq_record_parser #(
  parameter int unsigned LONG_READ_RESERVE = 32768
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  fqp_in_if.sink      in_i,
  fqp_out_if.source   out_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i
);
  import fqp_pkg::*;

  fqp_cfg_t    cfg;
  fqp_status_t status;
  fqp_result_t result, out_res;

  logic       s1_valid_q;
  logic [7:0] s1_byte_q;
  logic       s1_end_q;
  logic       s1_fire, res_load, out_free, out_valid;

  assign out_free  = !out_valid || out_o.ready;
  assign s1_fire   = s1_valid_q && (!status.res_valid || out_free);
  assign res_load  = s1_fire && status.res_valid;
  assign in_i.ready = !s1_valid_q || s1_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_byte_q <= in_i.in_byte;
      s1_end_q  <= in_i.at_end;
    end
  end

  fqp_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  fqp_core #(
    .LONG_READ_RESERVE (LONG_READ_RESERVE)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .in_byte_i (s1_byte_q),
    .at_end_i  (s1_end_q),
    .fire_i    (s1_fire),
    .status_o  (status),
    .result_o  (result)
  );

  fqp_out_stage u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (res_load),
    .result_i (result),
    .ready_i  (out_o.ready),
    .valid_o  (out_valid),
    .result_o (out_res)
  );

  assign out_o.valid       = out_valid;
  assign out_o.kind        = out_res.kind;
  assign out_o.value       = out_res.value;
  assign out_o.record_len  = out_res.record_len;
  assign out_o.line_number = out_res.line_number;
  assign out_o.chunk_reads = out_res.chunk_reads;
  assign out_o.chunk_full  = out_res.chunk_full;

`ifndef SYNTHESIS
  a_halt_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.halted |-> !status.res_valid)
    else $error("halted parser produced a result");

  a_terminal_halts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_load && (result.kind == KIND_CLEAN_END || result.kind == KIND_BAD_MARKER
                  || result.kind == KIND_INCOMPLETE)) |=> status.halted)
    else $error("terminal result did not halt the parser");

  a_full_only_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> (!out_res.chunk_full || out_res.kind == KIND_DONE))
    else $error("chunk_full set on a result other than record done");
`endif
endmodule

>>> tb/fastq_record_parser_tb.sv
// testbench for the fastq record parser: random and directed fastq text checked against a parser model
module fastq_record_parser_tb;
  import fqp_pkg::*;

  localparam int unsigned LONG_READ_RESERVE = 32768;
  localparam int ITEM_TARGET = 1000;
  localparam int SETTLE_CYCLES = 4;
  localparam logic [1:0] CFG_UNUSED_IDX = 2'd3;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [31:0] cfg_data_i;

  fqp_in_if  in_ch ();
  fqp_out_if out_ch ();

  fastq_record_parser #(
    .LONG_READ_RESERVE(LONG_READ_RESERVE)
  ) u_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_ch),
    .out_o     (out_ch),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  // parser model state
  fqp_cfg_t    cfg_model;
  fqp_phase_e  fq_phase;
  logic [31:0] lines_seen;
  logic [15:0] qual_count;
  logic [31:0] chunk_copies;
  logic [39:0] chunk_bases;

  fqp_result_t parse_emits_q[$];
  int          mismatches = 0;
  int          items_sent = 0;
  bit          sender_gaps_on = 1'b1;
  bit          sink_stalls_on = 1'b1;
  logic [7:0]  base_set [5] = '{"A", "C", "G", "T", "N"};

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #24000000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic void bump_line();
    if (lines_seen != 32'hFFFF_FFFF) lines_seen++;
  endfunction

  function automatic fqp_result_t mk_result(input fqp_kind_e k, input logic [7:0] v);
    fqp_result_t r;
    r = '0;
    r.kind = k;
    r.value = v;
    r.line_number = lines_seen;
    r.chunk_reads = chunk_copies;
    return r;
  endfunction

  function automatic fqp_result_t close_record();
    logic [63:0] mult;
    logic [63:0] rsum;
    logic [63:0] bsum;
    fqp_result_t r;
    mult = 64'($countones(cfg_model.orient_flags));
    rsum = 64'(chunk_copies) + mult;
    bsum = 64'(chunk_bases) + mult * 64'(qual_count);
    chunk_copies = (rsum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : rsum[31:0];
    chunk_bases = (bsum > 64'hFF_FFFF_FFFF) ? 40'hFF_FFFF_FFFF : bsum[39:0];
    // chunk_reads reports the count before any restart
    r = mk_result(KIND_DONE, 8'h00);
    r.record_len = qual_count;
    r.chunk_full = (64'(chunk_copies) + mult > 64'(cfg_model.read_limit)) ||
                   (64'(chunk_bases) + mult * 64'(LONG_READ_RESERVE) > 64'(cfg_model.max_bases));
    if (r.chunk_full) begin
      chunk_copies = '0;
      chunk_bases = '0;
    end
    qual_count = '0;
    fq_phase = PH_GAP;
    return r;
  endfunction

  function automatic bit parse_byte(input logic [7:0] c, input logic fin,
                                    output fqp_result_t r);
    logic eol;
    eol = (c == CH_NL) || (c == CH_NUL);
    r = '0;
    if (fq_phase == PH_HALT) return 1'b0;
    if (fq_phase == PH_GAP) begin
      if (fin) begin
        fq_phase = PH_HALT;
        r = mk_result(KIND_CLEAN_END, 8'h00);
        return 1'b1;
      end
      if (c == CH_NL) begin
        bump_line();
        return 1'b0;
      end
      if (c == CH_SP) return 1'b0;
      if (c == CH_AT) begin
        fq_phase = PH_NAME;
        qual_count = '0;
        return 1'b0;
      end
      fq_phase = PH_HALT;
      r = mk_result(KIND_BAD_MARKER, c);
      return 1'b1;
    end
    if (fin) begin
      fq_phase = PH_HALT;
      r = mk_result(KIND_INCOMPLETE, 8'h00);
      return 1'b1;
    end
    case (fq_phase)
      PH_NAME: begin
        if (eol) begin
          bump_line();
          fq_phase = PH_BASES;
          return 1'b0;
        end
        r = mk_result(KIND_NAME, c);
        return 1'b1;
      end
      PH_BASES: begin
        if (c == CH_PLUS || c == CH_NUL) begin
          fq_phase = PH_PLUS;
          return 1'b0;
        end
        if (c >= PRINT_LO && c <= PRINT_HI) begin
          r = mk_result(KIND_BASE, c);
          return 1'b1;
        end
        if (c == CH_NL) bump_line();
        return 1'b0;
      end
      PH_PLUS: begin
        if (eol) begin
          bump_line();
          qual_count = '0;
          fq_phase = PH_QUAL;
        end
        return 1'b0;
      end
      default: begin
        if (eol) begin
          bump_line();
          r = close_record();
          return 1'b1;
        end
        if (qual_count != 16'hFFFF) qual_count++;
        r = mk_result(KIND_QUAL, c);
        return 1'b1;
      end
    endcase
    return 1'b0;
  endfunction

  task automatic compare_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want, got);
    end
  endtask

  task automatic check_result();
    fqp_result_t want;
    if (parse_emits_q.size() == 0) begin
      mismatches++;
      $display("%0t: expected no result, actual kind %0d value %0h", $time,
               out_ch.kind, out_ch.value);
      return;
    end
    want = parse_emits_q.pop_front();
    compare_field("kind", want.kind, out_ch.kind);
    compare_field("value", want.value, out_ch.value);
    compare_field("record_len", want.record_len, out_ch.record_len);
    compare_field("line_number", want.line_number, out_ch.line_number);
    compare_field("chunk_reads", want.chunk_reads, out_ch.chunk_reads);
    compare_field("chunk_full", want.chunk_full, out_ch.chunk_full);
  endtask

  initial begin : result_sink
    int stall;
    out_ch.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      stall = sink_stalls_on ? $urandom_range(0, 15) : 0;
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!(out_ch.valid === 1'b1 && out_ch.ready === 1'b1));
      check_result();
    end
  end

  task automatic send_item(input logic [7:0] b, input logic fin);
    int gap;
    fqp_result_t r;
    gap = sender_gaps_on ? $urandom_range(0, 15) : 0;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.in_byte <= b;
    in_ch.at_end <= fin;
    do @(posedge clk_i); while (in_ch.ready !== 1'b1);
    items_sent++;
    if (parse_byte(b, fin, r)) parse_emits_q = {parse_emits_q, r};
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (parse_emits_q.size() != 0) @(posedge clk_i);
    // a byte with no result may still sit in the input register
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      CFG_ORIENT:    cfg_model.orient_flags = data[3:0];
      CFG_MAX_READS: cfg_model.read_limit = data;
      CFG_MAX_BASES: cfg_model.max_bases = data;
      default: ;
    endcase
  endtask

  task automatic apply_settings(input logic [31:0] orient, input logic [31:0] reads_cap,
                                input logic [31:0] bases_cap);
    wait_drained();
    write_reg(CFG_ORIENT, orient);
    write_reg(CFG_MAX_READS, reads_cap);
    write_reg(CFG_MAX_BASES, bases_cap);
  endtask

  function automatic logic [7:0] field_byte();
    logic [7:0] b;
    if ($urandom_range(0, 3) != 0) begin
      b = 8'($urandom_range(PRINT_LO, PRINT_HI));
    end else begin
      do b = 8'($urandom_range(1, 255)); while (b == CH_NL);
    end
    return b;
  endfunction

  // mostly nucleotides, some dropped or wrapped bytes
  function automatic logic [7:0] base_byte();
    logic [7:0] b;
    case ($urandom_range(0, 9))
      0: begin
        do b = 8'($urandom_range(1, 255)); while (b == CH_PLUS);
      end
      1: b = ($urandom_range(0, 1) != 0) ? CH_NL : CH_SP;
      default: b = base_set[3'($urandom_range(0, 4))];
    endcase
    return b;
  endfunction

  function automatic logic [7:0] line_end();
    return ($urandom_range(0, 7) == 0) ? CH_NUL : CH_NL;
  endfunction

  task automatic send_record(input int name_len, input int seq_len, input int qual_len);
    send_item(CH_AT, 1'b0);
    repeat (name_len) send_item(field_byte(), 1'b0);
    send_item(line_end(), 1'b0);
    repeat (seq_len) send_item(base_byte(), 1'b0);
    send_item(($urandom_range(0, 7) == 0) ? CH_NUL : CH_PLUS, 1'b0);
    // plus line may carry one to four random field bytes
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 4)) send_item(field_byte(), 1'b0);
    send_item(line_end(), 1'b0);
    repeat (qual_len) send_item(field_byte(), 1'b0);
    send_item(line_end(), 1'b0);
    repeat ($urandom_range(0, 2)) send_item(($urandom_range(0, 1) != 0) ? CH_SP : CH_NL, 1'b0);
  endtask

  task automatic send_random_record();
    send_record($urandom_range(0, 8), $urandom_range(0, 20), $urandom_range(0, 20));
  endtask

  task automatic apply_random_settings();
    logic [31:0] reads_cap;
    logic [31:0] bases_cap;
    case ($urandom_range(0, 3))
      0: reads_cap = '0;
      1: reads_cap = $urandom_range(1, 40);
      2: reads_cap = $urandom;
      default: reads_cap = '1;
    endcase
    case ($urandom_range(0, 3))
      0: bases_cap = '0;
      1: bases_cap = $urandom_range(32768, 400000);
      2: bases_cap = $urandom;
      default: bases_cap = '1;
    endcase
    apply_settings($urandom, reads_cap, bases_cap);
  endtask

  // reset register values, zero bytes closing every field, byte extremes
  task automatic test_directed_bytes();
    logic [7:0] stream [$];
    stream = '{CH_SP, CH_NL, CH_AT, 8'h01, 8'hFF, CH_NL,
               "A", CH_SP, PRINT_HI, PRINT_LO, 8'h7F, CH_NL, 8'h80, CH_PLUS,
               "x", CH_NL, 8'hFF, 8'h01, CH_NUL,
               CH_AT, CH_NUL, CH_NUL, CH_NUL, CH_NL};
    foreach (stream[i]) send_item(stream[i], 1'b0);
  endtask

  task automatic test_register_extremes();
    // no copies; upper orient bits are ignored
    apply_settings(32'hFFFF_FFF0, '1, '1);
    repeat (3) send_random_record();
    // nothing fits even in an empty chunk
    apply_settings(32'h0000_000F, '0, '0);
    write_reg(CFG_UNUSED_IDX, $urandom);
    repeat (3) send_random_record();
    apply_settings(32'h0000_000F, '1, '1);
    repeat (3) send_random_record();
    apply_settings(32'h0000_0001, 32'd3, 32'd32818);
    repeat (6) send_random_record();
    apply_settings(32'h0000_0006, 32'd5, 32'd200000);
    repeat (6) send_random_record();
  endtask

  task automatic test_random_stream();
    int start;
    int next_cfg;
    start = items_sent;
    next_cfg = 0;
    while (items_sent - start < ITEM_TARGET) begin
      if (items_sent - start >= next_cfg) begin
        apply_random_settings();
        next_cfg = items_sent - start + $urandom_range(100, 300);
      end
      sender_gaps_on = ($urandom_range(0, 3) != 0);
      sink_stalls_on = ($urandom_range(0, 3) != 0);
      send_random_record();
    end
    sender_gaps_on = 1'b1;
    sink_stalls_on = 1'b1;
  endtask

  // one way of stopping per run, then the parser must stay silent
  task automatic test_stream_end();
    logic [7:0] b;
    int stage;
    case ($urandom_range(0, 2))
      0: send_item(8'($urandom_range(0, 255)), 1'b1);
      1: begin
        do b = 8'($urandom_range(0, 255)); while (b == CH_SP || b == CH_NL || b == CH_AT);
        send_item(b, 1'b0);
      end
      default: begin
        // cut a record short inside one of its four fields
        stage = $urandom_range(0, 3);
        send_item(CH_AT, 1'b0);
        repeat ($urandom_range(0, 4)) send_item(field_byte(), 1'b0);
        if (stage >= 1) begin
          send_item(CH_NL, 1'b0);
          repeat ($urandom_range(0, 6)) send_item(base_byte(), 1'b0);
        end
        if (stage >= 2) begin
          send_item(CH_PLUS, 1'b0);
          repeat ($urandom_range(0, 3)) send_item(field_byte(), 1'b0);
        end
        if (stage >= 3) begin
          send_item(CH_NL, 1'b0);
          repeat ($urandom_range(0, 6)) send_item(field_byte(), 1'b0);
        end
        send_item(8'($urandom_range(0, 255)), 1'b1);
      end
    endcase
    repeat (20) send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  initial begin
    cfg_model = '{orient_flags: 4'd1, read_limit: '1, max_bases: '1};
    fq_phase = PH_GAP;
    lines_seen = '0;
    qual_count = '0;
    chunk_copies = '0;
    chunk_bases = '0;
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= '0;
    cfg_data_i <= '0;
    in_ch.valid <= 1'b0;
    in_ch.in_byte <= '0;
    in_ch.at_end <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_bytes();
    test_register_extremes();
    test_random_stream();
    test_stream_end();
    wait_drained();
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
